// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared constants, operation codes and widths for the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OperandWidthDefault = 16;
   localparam int NumOutBits          = 33;
   localparam int DenOutBits          = 31;

   localparam logic [2:0] MODE_ADD   = 3'd0;
   localparam logic [2:0] MODE_SUB   = 3'd1;
   localparam logic [2:0] MODE_MUL   = 3'd2;
   localparam logic [2:0] MODE_DIV   = 3'd3;
   localparam logic [2:0] MODE_SCALE = 3'd4;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // Operation codes for the shared datapath unit.
   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_MOD = 2'd1;
   localparam logic [1:0] OP_DIV = 2'd2;

   // Command to the shared unit.
   typedef struct packed {
      logic       go;
      logic [1:0] op;
   } unit_cmd_type;

endpackage

// ===== design/rational_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or scales signed fractions and
// returns the result reduced to lowest terms.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy stays high while
// the request is worked on and drops in the cycle in which the result strobe
// rsp_valid is given; the strobe lasts one cycle and the receiver must take it
// as it comes. Every step runs through one shared unit that handles one bit
// per cycle, and the sequencer waits for each multiply, remainder or divide
// to finish before it issues the next. A request that is not in error uses
// two products (three for add and subtract) and, unless its result is zero,
// one remainder per Euclid step and two divides, so how long busy stays high
// depends on the operands. A request that gives an error holds busy for one
// cycle, and its strobe follows in the next.
module rational_arithmetic_unit_top
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [2:0]                      req_mode,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_scale_factor,
   output logic                            rsp_valid,
   output logic signed [NumOutBits-1:0]    rsp_result_num,
   output logic [DenOutBits-1:0]           rsp_result_den,
   output logic                            rsp_status
);

   rau_seq #(.OperandWidth(OPERAND_WIDTH)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_a_num        (req_a_num),
      .req_a_den        (req_a_den),
      .req_b_num        (req_b_num),
      .req_b_den        (req_b_den),
      .req_scale_factor (req_scale_factor),
      .rsp_valid        (rsp_valid),
      .rsp_result_num   (rsp_result_num),
      .rsp_result_den   (rsp_result_den),
      .rsp_status       (rsp_status)
   );

   // A result is only given while a request is in progress.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without request");

   // The block is idle after giving a result.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy after result");

   // An error result is always zero over one.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ERROR) |->
         (rsp_result_num == '0 && rsp_result_den == DenOutBits'(1)))
      else $error("error result not 0/1");

endmodule

// ===== design/rau_unit.sv =====
// ----------------------------------------------------------------------------
// Rational shared arithmetic unit
// Multi-cycle unsigned multiply (shift-add) and divide/modulo (restoring),
// one bit per cycle.
// ----------------------------------------------------------------------------
module rau_unit
   import rau_pkg::*;
#(
   parameter int W = 2 * OperandWidthDefault + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  unit_cmd_type       cmd,
   input  logic [W-1:0]       op_a,
   input  logic [W-1:0]       op_b,
   output logic               done,
   output logic [W-1:0]       res
);

   localparam int CW = $clog2(W + 1);

   logic           busy_ff, busy_in;
   logic [1:0]     op_ff, op_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]   acc_ff, acc_in;   // product or remainder
   logic [W-1:0]   sh_ff, sh_in;     // multiplier or dividend / quotient
   logic [W-1:0]   b_ff, b_in;
   logic           done_ff, done_in;
   logic [W:0]     trial;

   // One step of the selected operation per cycle.
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      b_in    = b_ff;
      done_in = 1'b0;
      trial   = '0;
      if (cmd.go) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = CW'(W);
         acc_in  = '0;
         sh_in   = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            // Least significant multiplier bit first; multiplicand shifts left.
            if (sh_ff[0]) begin
               acc_in = acc_ff + b_ff;
            end
            sh_in = sh_ff >> 1;
            b_in  = b_ff << 1;
         end else begin
            trial = {acc_ff, sh_ff[W-1]} - {1'b0, b_ff};
            if (!trial[W]) begin
               acc_in = trial[W-1:0];
               sh_in  = {sh_ff[W-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[W-2:0], sh_ff[W-1]};
               sh_in  = {sh_ff[W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign res  = (op_ff == OP_DIV) ? sh_ff : acc_ff;

endmodule

// ===== design/rau_seq.sv =====
// ----------------------------------------------------------------------------
// Rational unit sequencer
// Steps through cross products, Euclid's algorithm and the final reductions.
// ----------------------------------------------------------------------------
module rau_seq
   import rau_pkg::*;
#(
   parameter int OperandWidth = OperandWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     req_mode,
   input  logic signed [OperandWidth-1:0] req_a_num,
   input  logic signed [OperandWidth-1:0] req_a_den,
   input  logic signed [OperandWidth-1:0] req_b_num,
   input  logic signed [OperandWidth-1:0] req_b_den,
   input  logic signed [OperandWidth-1:0] req_scale_factor,
   output logic                           rsp_valid,
   output logic signed [NumOutBits-1:0]   rsp_result_num,
   output logic [DenOutBits-1:0]          rsp_result_den,
   output logic                           rsp_status
);

   localparam int OW = OperandWidth;
   localparam int W  = 2 * OW + 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_P1   = 4'd1;   // first numerator product
   localparam logic [3:0] S_P2   = 4'd2;   // denominator product
   localparam logic [3:0] S_P3   = 4'd3;   // second numerator product
   localparam logic [3:0] S_GCD  = 4'd4;   // Euclid remainder step
   localparam logic [3:0] S_DN   = 4'd5;   // numerator / gcd
   localparam logic [3:0] S_DD   = 4'd6;   // Euclid remainder or denominator / gcd
   localparam logic [3:0] S_OUT  = 4'd7;
   localparam logic [3:0] S_WAIT = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    ret_ff, ret_in;      // state to go to after unit finishes
   logic [2:0]    mode_ff, mode_in;
   logic [OW-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in, sf_ff, sf_in;
   logic          ann_ff, ann_in, adn_ff, adn_in, bnn_ff, bnn_in, bdn_ff, bdn_in;
   logic          sfn_ff, sfn_in;
   logic [W-1:0]  p_ff, p_in, n_ff, n_in, d_ff, d_in, ga_ff, ga_in, gb_ff, gb_in;
   logic          pn_ff, pn_in, nn_ff, nn_in, dn_ff, dn_in;
   logic [W-1:0]  qn_ff, qn_in;
   logic          out_v_ff, out_v_in, st_ff, st_in;
   logic [W-1:0]  onum_ff, onum_in, oden_ff, oden_in;

   unit_cmd_type  cmd;
   logic [W-1:0]  ua, ub, ures;
   logic          udone;
   logic [W-1:0]  sum_mag;
   logic          sum_neg;
   logic          q_neg;
   logic          err;

   rau_unit #(.W(W)) u_unit (
      .clock (clock), .reset (reset), .cmd (cmd),
      .op_a (ua), .op_b (ub), .done (udone), .res (ures)
   );

   // Magnitude of a signed operand.
   function automatic logic [OW-1:0] mag_of(input logic [OW-1:0] v);
      mag_of = v[OW-1] ? (~v + 1'b1) : v;
   endfunction

   // Input error screening.
   assign err = (req_mode > MODE_SCALE) || (req_a_den == '0) ||
                ((req_mode < MODE_SCALE) && (req_b_den == '0)) ||
                ((req_mode == MODE_DIV) && (req_b_num == '0));

   // Signed magnitude sum of first product with second product.
   always_comb begin
      q_neg = (mode_ff == MODE_SUB) ? ~(bnn_ff ^ adn_ff) : (bnn_ff ^ adn_ff);
      if (pn_ff == q_neg) begin
         sum_mag = p_ff + ures;
         sum_neg = pn_ff;
      end else if (p_ff >= ures) begin
         sum_mag = p_ff - ures;
         sum_neg = pn_ff;
      end else begin
         sum_mag = ures - p_ff;
         sum_neg = q_neg;
      end
   end

   // Main sequencer.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      mode_in  = mode_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff; sf_in = sf_ff;
      ann_in = ann_ff; adn_in = adn_ff; bnn_in = bnn_ff; bdn_in = bdn_ff; sfn_in = sfn_ff;
      p_in = p_ff; n_in = n_ff; d_in = d_ff; ga_in = ga_ff; gb_in = gb_ff;
      pn_in = pn_ff; nn_in = nn_ff; dn_in = dn_ff; qn_in = qn_ff;
      out_v_in = 1'b0;
      st_in    = st_ff;
      onum_in  = onum_ff;
      oden_in  = oden_ff;
      cmd      = '0;
      ua       = '0;
      ub       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               an_in = mag_of(req_a_num);  ann_in = req_a_num[OW-1];
               ad_in = mag_of(req_a_den);  adn_in = req_a_den[OW-1];
               bn_in = mag_of(req_b_num);  bnn_in = req_b_num[OW-1];
               bd_in = mag_of(req_b_den);  bdn_in = req_b_den[OW-1];
               sf_in = mag_of(req_scale_factor); sfn_in = req_scale_factor[OW-1];
               if (err) begin
                  st_in    = STATUS_ERROR;
                  onum_in  = '0;
                  oden_in  = W'(1);
                  state_in = S_OUT;
               end else begin
                  st_in    = STATUS_OK;
                  state_in = S_P1;
               end
            end
         end
         S_P1: begin
            // Start first product: an*bd, an*bn, or sf*an.
            cmd.go = 1'b1;
            cmd.op = OP_MUL;
            ua = W'(an_ff);
            case (mode_ff)
               MODE_MUL:   ub = W'(bn_ff);
               MODE_SCALE: ub = W'(sf_ff);
               default:    ub = W'(bd_ff);
            endcase
            state_in = S_WAIT;
            ret_in   = S_P2;
         end
         S_P2: begin
            // First product in hand; start the next one.
            p_in  = ures;
            case (mode_ff)
               MODE_MUL:   pn_in = ann_ff ^ bnn_ff;
               MODE_SCALE: pn_in = ann_ff ^ sfn_ff;
               default:    pn_in = ann_ff ^ bdn_ff;
            endcase
            cmd.go = 1'b1;
            cmd.op = OP_MUL;
            ua = W'(ad_ff);
            case (mode_ff)
               MODE_DIV:   ub = W'(bn_ff);
               MODE_SCALE: ub = W'(1);
               default:    ub = W'(bd_ff);
            endcase
            state_in = S_WAIT;
            ret_in   = ((mode_ff == MODE_ADD) || (mode_ff == MODE_SUB)) ? S_P3 : S_GCD;
            qn_in    = '0;
         end
         S_P3: begin
            // Denominator ad*bd in hand; start bn*ad for the sum.
            qn_in  = ures;
            cmd.go = 1'b1;
            cmd.op = OP_MUL;
            ua = W'(bn_ff);
            ub = W'(ad_ff);
            state_in = S_WAIT;
            ret_in   = S_GCD;
         end
         S_GCD: begin
            if (ga_ff == '0 && gb_ff == '0 && n_ff == '0 && d_ff == '0) begin
               // First visit: capture numerator and denominator.
               if ((mode_ff == MODE_ADD) || (mode_ff == MODE_SUB)) begin
                  n_in  = sum_mag;
                  nn_in = (sum_mag == '0) ? 1'b0 : sum_neg;
                  d_in  = qn_ff;
                  dn_in = adn_ff ^ bdn_ff;
               end else begin
                  n_in  = p_ff;
                  nn_in = pn_ff;
                  d_in  = ures;
                  case (mode_ff)
                     MODE_DIV:   dn_in = adn_ff ^ bnn_ff;
                     MODE_SCALE: dn_in = adn_ff;
                     default:    dn_in = adn_ff ^ bdn_ff;
                  endcase
                  if ((mode_ff == MODE_MUL || mode_ff == MODE_DIV) && p_ff == '0) begin
                     nn_in = 1'b0;
                  end
               end
               if (((mode_ff == MODE_ADD) || (mode_ff == MODE_SUB)) ? (sum_mag == '0)
                                                                   : (p_ff == '0)) begin
                  onum_in  = '0;
                  oden_in  = W'(1);
                  state_in = S_OUT;
               end else begin
                  ga_in = ((mode_ff == MODE_ADD) || (mode_ff == MODE_SUB)) ? sum_mag : p_ff;
                  gb_in = ((mode_ff == MODE_ADD) || (mode_ff == MODE_SUB)) ? qn_ff : ures;
               end
            end else if (gb_ff == '0) begin
               // gcd is ga; divide numerator.
               cmd.go = 1'b1;
               cmd.op = OP_DIV;
               ua = n_ff;
               ub = ga_ff;
               state_in = S_WAIT;
               ret_in   = S_DN;
            end else begin
               cmd.go = 1'b1;
               cmd.op = OP_MOD;
               ua = ga_ff;
               ub = gb_ff;
               ga_in    = gb_ff;
               state_in = S_WAIT;
               ret_in   = S_DD;
               qn_in    = '1;   // marks remainder pending
            end
         end
         S_DD: begin
            if (qn_ff == '1) begin
               // Remainder returned: continue Euclid.
               gb_in    = ures;
               qn_in    = '0;
               state_in = S_GCD;
            end else begin
               // Reduced denominator returned.
               oden_in  = ures;
               state_in = S_OUT;
            end
         end
         S_DN: begin
            onum_in = (nn_ff != dn_ff) ? (~ures + 1'b1) : ures;
            cmd.go  = 1'b1;
            cmd.op  = OP_DIV;
            ua = d_ff;
            ub = ga_ff;
            qn_in    = '0;
            state_in = S_WAIT;
            ret_in   = S_DD;
         end
         S_WAIT: begin
            if (udone) begin
               state_in = ret_ff;
            end
         end
         S_OUT: begin
            out_v_in = 1'b1;
            ga_in = '0; gb_in = '0; n_in = '0; d_in = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         ga_ff <= '0; gb_ff <= '0; n_ff <= '0; d_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         ga_ff <= ga_in; gb_ff <= gb_in; n_ff <= n_in; d_ff <= d_in;
      end
      ret_ff <= ret_in;  mode_ff <= mode_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in; sf_ff <= sf_in;
      ann_ff <= ann_in; adn_ff <= adn_in; bnn_ff <= bnn_in; bdn_ff <= bdn_in;
      sfn_ff <= sfn_in;
      p_ff <= p_in; pn_ff <= pn_in; nn_ff <= nn_in; dn_ff <= dn_in; qn_ff <= qn_in;
      st_ff <= st_in; onum_ff <= onum_in; oden_ff <= oden_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = out_v_ff;
   assign rsp_result_num = NumOutBits'($signed(onum_ff));
   assign rsp_result_den = DenOutBits'(oden_ff);
   assign rsp_status     = st_ff;

endmodule
